// ===== rtl/ook_pulse_code_transmitter_defines.svh =====
// ----------------------------------------------------------------------------
// OOK transmitter assertion macros
// Shared concurrent assertion shorthands for the OOK transmitter RTL.
// ----------------------------------------------------------------------------
`ifndef OOK_PULSE_CODE_TRANSMITTER_DEFINES_SVH
`define OOK_PULSE_CODE_TRANSMITTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define OOKTX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define OOKTX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ooktx_pkg.sv =====
// ----------------------------------------------------------------------------
// OOK transmitter package
// Widths, register codes, reset values and shared types.
// ----------------------------------------------------------------------------
package ooktx_pkg;

  localparam int unsigned CodeBitsDef = 32;
  localparam int unsigned CodeWordW   = 32;
  localparam int unsigned CodeLenW    = 6;
  localparam int unsigned TickW       = 16;
  localparam int unsigned RepW        = 8;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned CfgIdxW     = 2;

  localparam logic [RepW-1:0]  RepeatRst = RepW'(4);
  localparam logic [TickW-1:0] ShortRst  = TickW'(172);
  localparam logic [TickW-1:0] LongRst   = TickW'(516);
  localparam logic [TickW-1:0] GapRst    = TickW'(5332);

  localparam logic CmdTick  = 1'b0;
  localparam logic CmdStart = 1'b1;

  typedef enum logic [1:0] {
    PhBitHigh,
    PhBitLow,
    PhSyncHigh,
    PhSyncLow
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegRepeat,
    RegShort,
    RegLong,
    RegGap
  } cfg_reg_e;

  typedef struct packed {
    logic [RepW-1:0]  repeat_count;
    logic [TickW-1:0] short_ticks;
    logic [TickW-1:0] long_ticks;
    logic [TickW-1:0] gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic done_res;
    logic start_refused;
  } res_t;

  // A zero duration register counts as one tick.
  function automatic logic [TickW-1:0] at_least_one(logic [TickW-1:0] v);
    return (v == '0) ? TickW'(1) : v;
  endfunction

endpackage

// ===== rtl/ooktx_if.sv =====
// ----------------------------------------------------------------------------
// OOK transmitter channels
// Valid/ready channels for command items and per-tick results.
// ----------------------------------------------------------------------------
interface ooktx_in_if
  import ooktx_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [CodeWordW-1:0] code_word;
  logic [CodeLenW-1:0]  code_length;

  modport source (output valid, command, code_word, code_length, input ready);
  modport sink   (input valid, command, code_word, code_length, output ready);
endinterface

interface ooktx_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic done_res;
  logic start_refused;

  modport source (output valid, line_level, busy_res, done_res, start_refused,
                  input ready);
  modport sink   (input valid, line_level, busy_res, done_res, start_refused,
                  output ready);
endinterface

// ===== rtl/ook_pulse_code_transmitter.sv =====
// ----------------------------------------------------------------------------
// OOK pulse code transmitter
// Pulse-width coded on-off keying of a code word, one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries items: command 0 is one microsecond tick, command 1 starts
//   a transmission of code_length low-order bits of code_word, MSB first.
//   A start while a transmission runs is refused and flagged in its result.
//   out_ch returns one result per item: line level for that tick, busy,
//   done on the final tick of the last frame, and the start-refused flag.
//   cfg_* writes repeat count and short/long/gap tick lengths; write only
//   while idle. Each segment samples the timing registers as it begins.
// Timing:
//   One item per clock sustained while out_ch is ready. A result appears in
//   the cycle after its transfer on in_ch; the state update is a single pass
//   from the frame registers into the result register.
// Reset:
//   Line idle low, no transmission, registers back to 4/172/516/5332.
// Stall:
//   If out_ch is not ready the result register holds and in_ch.ready drops
//   until it drains; no tick is lost since ticks arrive as transfers.
// ----------------------------------------------------------------------------
`include "ook_pulse_code_transmitter_defines.svh"

module ook_pulse_code_transmitter
  import ooktx_pkg::*;
#(
  parameter int unsigned CODE_BITS = CodeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ooktx_in_if.sink            in_ch,
  ooktx_out_if.source         out_ch,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg;
  res_t res_next;
  res_t res_out;
  logic accept;
  logic can_load;

  // Transfer on the command channel.
  assign accept      = in_ch.valid && can_load;
  assign in_ch.ready = can_load;

  ooktx_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Frame sequencer: computes the result of the item being transferred.
  ooktx_core #(
    .CODE_BITS (CODE_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .accept_i      (accept),
    .command_i     (in_ch.command),
    .code_word_i   (in_ch.code_word),
    .code_length_i (in_ch.code_length),
    .res_o         (res_next)
  );

  // Result register decouples the receiver's stalls from the sequencer.
  ooktx_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .res_i      (res_next),
    .ready_i    (out_ch.ready),
    .can_load_o (can_load),
    .valid_o    (out_ch.valid),
    .res_o      (res_out)
  );

  assign out_ch.line_level    = res_out.line_level;
  assign out_ch.busy_res      = res_out.busy_res;
  assign out_ch.done_res      = res_out.done_res;
  assign out_ch.start_refused = res_out.start_refused;

  `OOKTX_ASSERT_NEXT(a_result_follows, in_ch.valid && in_ch.ready, out_ch.valid, "no result after transfer")
  `OOKTX_ASSERT_NOW(a_done_busy, out_ch.valid && out_ch.done_res, out_ch.busy_res && !out_ch.start_refused, "done without busy")
  `OOKTX_ASSERT_NOW(a_level_busy, out_ch.valid && out_ch.line_level, out_ch.busy_res, "line high while idle")
  `OOKTX_ASSERT_NOW(a_stall_blocks, out_ch.valid && !out_ch.ready, !in_ch.ready, "accepted into full register")

endmodule

// ===== rtl/ooktx_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// OOK transmitter configuration registers
// Repeat count and pulse timing registers behind a plain write port.
// ----------------------------------------------------------------------------
module ooktx_cfg_regs
  import ooktx_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegRepeat: cfg_d.repeat_count = cfg_data_i[RepW-1:0];
        RegShort:  cfg_d.short_ticks  = cfg_data_i[TickW-1:0];
        RegLong:   cfg_d.long_ticks   = cfg_data_i[TickW-1:0];
        RegGap:    cfg_d.gap_ticks    = cfg_data_i[TickW-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_count <= RepeatRst;
      cfg_q.short_ticks  <= ShortRst;
      cfg_q.long_ticks   <= LongRst;
      cfg_q.gap_ticks    <= GapRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/ooktx_core.sv =====
// ----------------------------------------------------------------------------
// OOK transmitter sequencer
// Frame state and one-tick update of phase, bit and segment counters.
// ----------------------------------------------------------------------------
module ooktx_core
  import ooktx_pkg::*;
#(
  parameter int unsigned CODE_BITS = CodeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 accept_i,
  input  logic                 command_i,
  input  logic [CodeWordW-1:0] code_word_i,
  input  logic [CodeLenW-1:0]  code_length_i,
  output res_t                 res_o
);

  localparam int unsigned LenW = $clog2(CODE_BITS + 1);
  localparam int unsigned IdxW = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
  localparam int unsigned CmpW = (LenW > CodeLenW) ? LenW : CodeLenW;

  logic [CODE_BITS-1:0] code_q, code_d;
  logic [LenW-1:0]      len_q, len_d;
  logic [LenW-1:0]      pos_q, pos_d;
  logic [RepW-1:0]      rep_q, rep_d;
  phase_e               ph_q, ph_d;
  logic [TickW-1:0]     ticks_q, ticks_d, ticks_upd;
  logic                 act_q, act_d;
  logic                 enter;

  logic [CmpW-1:0]  len_ext;
  logic [LenW-1:0]  len_sat;
  logic [TickW-1:0] ticks_dec;
  logic [RepW-1:0]  rep_dec;
  logic [LenW-1:0]  pos_dec;
  logic [IdxW-1:0]  bit_idx;
  logic             cur_bit;
  logic [TickW-1:0] dur;

  // Lengths past the code register saturate.
  assign len_ext   = CmpW'(code_length_i);
  assign len_sat   = (len_ext > CmpW'(CODE_BITS)) ? LenW'(CODE_BITS) : LenW'(len_ext);
  assign ticks_dec = ticks_q - TickW'(ticks_q != '0);
  assign rep_dec   = rep_q - RepW'(rep_q != '0);
  assign pos_dec   = pos_q - LenW'(pos_q != '0);

  always_comb begin
    code_d    = code_q;
    len_d     = len_q;
    pos_d     = pos_q;
    rep_d     = rep_q;
    ph_d      = ph_q;
    ticks_upd = ticks_q;
    act_d     = act_q;
    enter     = 1'b0;
    res_o     = '0;
    if (accept_i) begin
      if (command_i == CmdStart) begin
        if (act_q) begin
          res_o.start_refused = 1'b1;
        end else begin
          code_d = CODE_BITS'(code_word_i);
          len_d  = len_sat;
          rep_d  = cfg_i.repeat_count;
          if (cfg_i.repeat_count != '0) begin
            act_d = 1'b1;
            pos_d = len_sat;
            ph_d  = (len_sat != '0) ? PhBitHigh : PhSyncHigh;
            enter = 1'b1;
          end
        end
        res_o.line_level = act_d && (ph_d == PhBitHigh || ph_d == PhSyncHigh);
        res_o.busy_res   = act_d;
      end else if (act_q) begin
        res_o.line_level = (ph_q == PhBitHigh || ph_q == PhSyncHigh);
        res_o.busy_res   = 1'b1;
        ticks_upd        = ticks_dec;
        if (ticks_dec == '0) begin
          unique case (ph_q)
            PhBitHigh: begin
              ph_d  = PhBitLow;
              enter = 1'b1;
            end
            PhBitLow: begin
              pos_d = pos_dec;
              ph_d  = (pos_dec != '0) ? PhBitHigh : PhSyncHigh;
              enter = 1'b1;
            end
            PhSyncHigh: begin
              ph_d  = PhSyncLow;
              enter = 1'b1;
            end
            PhSyncLow: begin
              rep_d = rep_dec;
              if (rep_dec == '0) begin
                act_d          = 1'b0;
                res_o.done_res = 1'b1;
                ph_d           = PhBitHigh;
                pos_d          = '0;
              end else begin
                pos_d = len_q;
                ph_d  = (len_q != '0) ? PhBitHigh : PhSyncHigh;
                enter = 1'b1;
              end
            end
            default: ph_d = ph_q;
          endcase
        end
      end
    end
  end

  // Segment duration for the phase being entered, from the live registers.
  assign bit_idx = IdxW'(pos_d - LenW'(1));
  assign cur_bit = (pos_d != '0) && code_d[bit_idx];

  always_comb begin
    unique case (ph_d)
      PhBitHigh:  dur = cur_bit ? cfg_i.long_ticks : cfg_i.short_ticks;
      PhBitLow:   dur = cur_bit ? cfg_i.short_ticks : cfg_i.long_ticks;
      PhSyncHigh: dur = cfg_i.short_ticks;
      PhSyncLow:  dur = cfg_i.gap_ticks;
      default:    dur = cfg_i.gap_ticks;
    endcase
    ticks_d = enter ? at_least_one(dur) : ticks_upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      rep_q   <= '0;
      ph_q    <= PhBitHigh;
      ticks_q <= '0;
      act_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      rep_q   <= rep_d;
      ph_q    <= ph_d;
      ticks_q <= ticks_d;
      act_q   <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    len_q  <= len_d;
  end

endmodule

// ===== rtl/ooktx_out_reg.sv =====
// ----------------------------------------------------------------------------
// OOK transmitter result register
// Holds one result for the receiver; refills while being drained.
// ----------------------------------------------------------------------------
module ooktx_out_reg
  import ooktx_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic ready_i,
  output logic can_load_o,
  output logic valid_o,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign can_load_o = !valid_q || ready_i;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
